// File: rtl/core/btcc_pkg.sv
// ----------------------------------------------------------------------------
// btcc_pkg
// Shared types and constants for the track bitmap consistency checker.
// ----------------------------------------------------------------------------
package btcc_pkg;

  localparam int unsigned DEF_MAX_BITMAP_BYTES = 32;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned ONES_W  = 4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE_BITS    = 1'b0,
    CFG_COUNTER_PRESENT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              reverse_bits;
    logic              counter_present;
  } cfg_t;

  // per-byte evaluation handed to the accumulator
  typedef struct packed {
    logic [ONES_W-1:0] ones;      // set bits in the byte (zero past the maximum)
    logic              bad;       // set bit on a nonexistent sector
    logic              in_range;  // byte lies below the maximum bitmap length
  } byte_eval_t;

endpackage

// File: rtl/core/bam_track_consistency_checker_unit.sv
// ----------------------------------------------------------------------------
// bam_track_consistency_checker_unit
// Checks one track's free-block bitmap, one byte per request, and reports the
// free count and consistency flags on the track's last byte.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | bitmap_byte, track_sectors, reported_free,
//          |                       | last_byte
//  out     | out_valid / out_stall | free_count, invalid_bits,
//          |                       | count_exceeds_sectors, count_mismatch
//  cfg     | cfg_write             | cfg_index, cfg_data
//
// One request per cycle sustained unless a last byte waits on a stalled result.
// A request is captured in the input register; its result, on a last byte, is
// registered in the result register when that byte advances. Synchronous reset
// clears track state, reverse off and counter present on. A stalled result holds
// the input register only when it holds a last byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module bam_track_consistency_checker_unit #(
  parameter int unsigned MAX_BITMAP_BYTES = btcc_pkg::DEF_MAX_BITMAP_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [btcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [btcc_pkg::BYTE_W-1:0]    bitmap_byte,
  input  logic [btcc_pkg::BYTE_W-1:0]    track_sectors,
  input  logic [btcc_pkg::BYTE_W-1:0]    reported_free,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [btcc_pkg::COUNT_W-1:0]   free_count,
  output logic                           invalid_bits,
  output logic                           count_exceeds_sectors,
  output logic                           count_mismatch
);
  import btcc_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_BITMAP_BYTES + 1);

  cfg_t              cfg;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic [BYTE_W-1:0] s1_sectors;
  logic [BYTE_W-1:0] s1_reported;
  logic              s1_last;
  logic              advance;
  logic [POS_W-1:0]  byte_position;
  byte_eval_t        eval;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_bits    <= 1'b0;
      cfg.counter_present <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REVERSE_BITS:    cfg.reverse_bits    <= cfg_data;
        CFG_COUNTER_PRESENT: cfg.counter_present <= cfg_data;
        default: ;
      endcase
    end
  end

  // a last byte needs a free result register; other bytes never wait
  assign advance  = s1_valid & (~s1_last | ~out_valid | ~out_stall);
  assign in_stall = s1_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte     <= bitmap_byte;
      s1_sectors  <= track_sectors;
      s1_reported <= reported_free;
      s1_last     <= last_byte;
    end
  end

  btcc_byte_eval #(
    .MAX_BITMAP_BYTES(MAX_BITMAP_BYTES),
    .POS_W           (POS_W)
  ) u_eval (
    .bitmap_byte     (s1_byte),
    .track_sectors   (s1_sectors),
    .reverse_bits    (cfg.reverse_bits),
    .byte_position   (byte_position),
    .eval            (eval)
  );

  btcc_track_accum #(
    .MAX_BITMAP_BYTES(MAX_BITMAP_BYTES),
    .POS_W           (POS_W)
  ) u_accum (
    .clk                  (clk),
    .rst                  (rst),
    .advance              (advance),
    .eval                 (eval),
    .track_sectors        (s1_sectors),
    .reported_free        (s1_reported),
    .last_byte            (s1_last),
    .counter_present      (cfg.counter_present),
    .byte_position        (byte_position),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .free_count           (free_count),
    .invalid_bits         (invalid_bits),
    .count_exceeds_sectors(count_exceeds_sectors),
    .count_mismatch       (count_mismatch)
  );

  // input stalls only behind a last byte waiting on a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked last byte");

  // a new result follows exactly a consumed last byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (advance && !s1_last && !(out_valid && out_stall)) |=> !out_valid)
    else $error("result produced without a last byte");

  // track state restarts after each last byte
  a_track_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (byte_position == '0))
    else $error("track state not cleared after last byte");

  // counted bits never exceed the bitmap length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_count <= COUNT_W'(MAX_BITMAP_BYTES * BYTE_W)))
    else $error("free count beyond bitmap size");

endmodule

// File: rtl/core/btcc_byte_eval.sv
// ----------------------------------------------------------------------------
// btcc_byte_eval
// Reorders one bitmap byte, masks it against the track's sector count and
// counts its set bits.
// ----------------------------------------------------------------------------
module btcc_byte_eval #(
  parameter int unsigned MAX_BITMAP_BYTES = btcc_pkg::DEF_MAX_BITMAP_BYTES,
  parameter int unsigned POS_W            = $clog2(MAX_BITMAP_BYTES + 1)
) (
  input  logic [btcc_pkg::BYTE_W-1:0] bitmap_byte,
  input  logic [btcc_pkg::BYTE_W-1:0] track_sectors,
  input  logic                        reverse_bits,
  input  logic [POS_W-1:0]            byte_position,
  output btcc_pkg::byte_eval_t        eval
);
  import btcc_pkg::*;

  // wide enough for the last sector number of the last byte and for the sector count
  localparam int unsigned SEC_W = ((POS_W + 3) > BYTE_W) ? (POS_W + 4) : (BYTE_W + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BITMAP_BYTES);

  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] allowed;
  logic [SEC_W-1:0]  first_sector;
  logic [SEC_W-1:0]  sectors_ext;
  logic [ONES_W-1:0] ones;
  logic              in_range;

  always_comb begin
    for (int j = 0; j < BYTE_W; j++) begin
      b[j] = reverse_bits ? bitmap_byte[BYTE_W-1-j] : bitmap_byte[j];
    end
  end

  assign first_sector = SEC_W'({byte_position, 3'b000});
  assign sectors_ext  = SEC_W'(track_sectors);
  assign in_range     = (byte_position < POS_MAX);

  // bit j is a real sector when 8*pos + j < sectors
  always_comb begin
    for (int j = 0; j < BYTE_W; j++) begin
      allowed[j] = sectors_ext > (first_sector + SEC_W'(j));
    end
  end

  always_comb begin
    ones = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      ones = ones + ONES_W'(b[j]);
    end
  end

  always_comb begin
    eval.in_range = in_range;
    eval.ones     = in_range ? ones : '0;
    eval.bad      = in_range ? |(b & ~allowed) : |b;
  end

endmodule

// File: rtl/core/btcc_track_accum.sv
// ----------------------------------------------------------------------------
// btcc_track_accum
// Per-track running state and the result register with its output handshake.
// ----------------------------------------------------------------------------
module btcc_track_accum #(
  parameter int unsigned MAX_BITMAP_BYTES = btcc_pkg::DEF_MAX_BITMAP_BYTES,
  parameter int unsigned POS_W            = $clog2(MAX_BITMAP_BYTES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  btcc_pkg::byte_eval_t         eval,
  input  logic [btcc_pkg::BYTE_W-1:0]  track_sectors,
  input  logic [btcc_pkg::BYTE_W-1:0]  reported_free,
  input  logic                         last_byte,
  input  logic                         counter_present,
  output logic [POS_W-1:0]             byte_position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [btcc_pkg::COUNT_W-1:0] free_count,
  output logic                         invalid_bits,
  output logic                         count_exceeds_sectors,
  output logic                         count_mismatch
);
  import btcc_pkg::*;

  logic [COUNT_W-1:0] bit_total;
  logic               bad_bit_seen;

  logic [COUNT_W-1:0] bit_total_next;
  logic               bad_next;
  logic [COUNT_W-1:0] reported_count;
  logic               emit;

  assign bit_total_next = bit_total + COUNT_W'(eval.ones);
  assign bad_next       = bad_bit_seen | eval.bad;
  assign reported_count = counter_present ? COUNT_W'(reported_free) : bit_total_next;
  assign emit           = advance & last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      bit_total     <= '0;
      bad_bit_seen  <= 1'b0;
    end else if (advance) begin
      if (last_byte) begin
        byte_position <= '0;
        bit_total     <= '0;
        bad_bit_seen  <= 1'b0;
      end else begin
        if (eval.in_range) begin
          byte_position <= byte_position + POS_W'(1);
        end
        bit_total    <= bit_total_next;
        bad_bit_seen <= bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      free_count            <= bit_total_next;
      invalid_bits          <= bad_next;
      count_exceeds_sectors <= reported_count > COUNT_W'(track_sectors);
      count_mismatch        <= reported_count != bit_total_next;
    end
  end

endmodule

// File: tb/tb_bam_track_consistency_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_bam_track_consistency_checker_unit
// Streams track bitmaps through the checker under every register setting.
// Expected free counts and flags are predicted from each accepted request and
// compared field by field with the results, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_bam_track_consistency_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import btcc_pkg::*;

  localparam int MAXB        = DEF_MAX_BITMAP_BYTES;
  localparam int PHASE_BYTES = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] bam;
    logic [BYTE_W-1:0] sectors;
    logic [BYTE_W-1:0] reported;
    logic              last;
  } bitmap_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] free_count;
    logic               invalid;
    logic               exceeds;
    logic               mismatch;
  } track_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REVERSE_BITS;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    bitmap_byte = '0;
  logic [BYTE_W-1:0]    track_sectors = '0;
  logic [BYTE_W-1:0]    reported_free = '0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COUNT_W-1:0]   free_count;
  logic                 invalid_bits;
  logic                 count_exceeds_sectors;
  logic                 count_mismatch;

  bam_track_consistency_checker_unit dut (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .bitmap_byte           (bitmap_byte),
    .track_sectors         (track_sectors),
    .reported_free         (reported_free),
    .last_byte             (last_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .free_count            (free_count),
    .invalid_bits          (invalid_bits),
    .count_exceeds_sectors (count_exceeds_sectors),
    .count_mismatch        (count_mismatch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state and register copies
  logic               rev_cfg = 1'b0;
  logic               cnt_cfg = 1'b1;
  logic [5:0]         pos_q = '0;
  logic [COUNT_W-1:0] total_q = '0;
  logic               bad_q = 1'b0;

  bitmap_req_t   pending[$];
  track_result_t expected_tracks[$];
  bitmap_req_t   cur_req;

  int queued_bytes = 0;
  int bytes_accepted = 0;
  int results_checked = 0;
  int invalid_seen = 0, exceeds_seen = 0, mismatch_seen = 0;
  int err_count = 0;
  int burst_left = 0, gap_left = 0;
  int hold_requests = 0, hold_seen = 0, hold_left = 0;
  int rx_mode = 0;
  int unsigned rx_cycle = 0;
  logic rx_stall_next;
  int idle_cycles = 0;

  function automatic logic [7:0] mirror(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = b[7-k];
    return r;
  endfunction

  function automatic int ones_in(input logic [7:0] b);
    int n;
    n = 0;
    for (int k = 0; k < 8; k++) n += b[k];
    return n;
  endfunction

  // sectors that exist within bitmap byte 'pos'
  function automatic logic [7:0] legal_mask(input int pos, input int secs);
    int first;
    first = pos * 8;
    if (secs >= first + 8) return 8'hFF;
    if (secs <= first) return 8'h00;
    return (8'd1 << (secs - first)) - 8'd1;
  endfunction

  task automatic account_byte(input bitmap_req_t r);
    logic [7:0]         b;
    logic [COUNT_W-1:0] rep;
    track_result_t      res;
    b = rev_cfg ? mirror(r.bam) : r.bam;
    if (pos_q >= MAXB) begin
      if (b != 0) bad_q = 1'b1;
    end else begin
      if ((b & ~legal_mask(pos_q, r.sectors)) != 0) bad_q = 1'b1;
      total_q = total_q + COUNT_W'(ones_in(b));
      pos_q = pos_q + 6'd1;
    end
    if (r.last) begin
      rep = cnt_cfg ? {1'b0, r.reported} : total_q;
      res.free_count = total_q;
      res.invalid    = bad_q;
      res.exceeds    = (rep > {1'b0, r.sectors});
      res.mismatch   = (rep != total_q);
      expected_tracks.push_back(res);
      pos_q = '0;
      total_q = '0;
      bad_q = 1'b0;
    end
  endtask

  task automatic push_req(input logic [7:0] b, input logic [7:0] s, input logic [7:0] rep,
                          input logic last);
    bitmap_req_t r;
    r = '{bam: b, sectors: s, reported: rep, last: last};
    pending.push_back(r);
    queued_bytes++;
  endtask

  // one well-formed track with random content
  task automatic add_track();
    int         secs, nbytes, fill, ones, rv;
    logic [7:0] b, s;
    secs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48);
    case ($urandom_range(0, 11))
      0:       nbytes = $urandom_range(MAXB, MAXB + 4);
      1, 2, 3: nbytes = $urandom_range(1, 6);
      default: nbytes = (secs + 7) / 8;
    endcase
    if (nbytes == 0) nbytes = 1;
    fill = $urandom_range(0, 5);
    ones = 0;
    for (int i = 0; i < nbytes; i++) begin
      s = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : 8'(secs);
      case (fill)
        0:       b = 8'($urandom()) & legal_mask(i, secs);
        1, 2:    b = 8'($urandom());
        3:       b = 8'hFF;
        4:       b = 8'h00;
        default: b = legal_mask(i, secs);
      endcase
      // keep legal fills legal under bit reversal
      if (rev_cfg && (fill == 0 || fill == 5)) b = mirror(b);
      if (i < MAXB) ones += ones_in(b);
      if (i == nbytes - 1) begin
        case ($urandom_range(0, 3))
          0:       rv = $urandom_range(0, 255);
          1:       rv = ($urandom_range(0, 1) != 0) ? ones + 1 : ones - 1;
          default: rv = ones;
        endcase
        if (rv < 0 || rv > 255) rv = $urandom_range(0, 255);
        push_req(b, s, 8'(rv), 1'b1);
      end else begin
        push_req(b, s, 8'($urandom()), 1'b0);
      end
    end
  endtask

  task automatic fill_phase(input int target);
    int start;
    start = queued_bytes;
    while (queued_bytes - start < target) begin
      if ($urandom_range(0, 9) == 0)
        push_req(8'($urandom()), 8'($urandom()), 8'($urandom()), $urandom_range(0, 2) == 0);
      else
        add_track();
    end
    push_req(8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b1);
  endtask

  // wait until every request is in and every result is out
  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || expected_tracks.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_set(input logic rev, input logic cnt);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_REVERSE_BITS;
    cfg_data  <= rev;
    @(posedge clk);
    cfg_index <= CFG_COUNTER_PRESENT;
    cfg_data  <= cnt;
    @(posedge clk);
    cfg_write <= 1'b0;
    rev_cfg = rev;
    cnt_cfg = cnt;
  endtask

  task automatic note_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        account_byte(cur_req);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_req = pending.pop_front();
          in_valid      <= 1'b1;
          bitmap_byte   <= cur_req.bam;
          track_sectors <= cur_req.sectors;
          reported_free <= cur_req.reported;
          last_byte     <= cur_req.last;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: randomly chosen stall pattern, plus a long hold on demand
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left == 0 && hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_stall_next = 1'b1;
      end else begin
        case (rx_mode)
          0:       rx_stall_next = 1'b0;
          1:       rx_stall_next = ($urandom_range(0, 2) == 0);
          2:       rx_stall_next = ($urandom_range(0, 3) != 0);
          default: rx_stall_next = (rx_cycle % 5) < 2;
        endcase
      end
      out_stall <= rx_stall_next;
    end
  end

  // result checker
  always @(posedge clk) begin
    track_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tracks.size() == 0) begin
        note_mismatch($sformatf("result with none pending: free_count=%0d", free_count));
      end else begin
        want = expected_tracks.pop_front();
        if (free_count !== want.free_count)
          note_mismatch($sformatf("track %0d free_count got %0d want %0d",
                                  results_checked, free_count, want.free_count));
        if (invalid_bits !== want.invalid)
          note_mismatch($sformatf("track %0d invalid_bits got %b want %b",
                                  results_checked, invalid_bits, want.invalid));
        if (count_exceeds_sectors !== want.exceeds)
          note_mismatch($sformatf("track %0d count_exceeds_sectors got %b want %b",
                                  results_checked, count_exceeds_sectors, want.exceeds));
        if (count_mismatch !== want.mismatch)
          note_mismatch($sformatf("track %0d count_mismatch got %b want %b",
                                  results_checked, count_mismatch, want.mismatch));
        invalid_seen  += want.invalid;
        exceeds_seen  += want.exceeds;
        mismatch_seen += want.mismatch;
      end
      results_checked++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic rev_list[4];
    logic cnt_list[4];
    rev_list = '{1'b1, 1'b0, 1'b1, 1'b0};
    cnt_list = '{1'b1, 1'b0, 1'b0, 1'b1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed tracks under reset settings
    push_req(8'hFF, 8'd8, 8'd8, 1'b1);        // clean full byte
    push_req(8'h00, 8'd0, 8'd0, 1'b1);        // empty track
    push_req(8'hFF, 8'd0, 8'd255, 1'b1);      // all flags raised
    push_req(8'h3F, 8'd5, 8'd6, 1'b1);        // bit on sector 5 of a 5-sector track
    push_req(8'hFF, 8'd17, 8'd3, 1'b0);       // sector count changes mid track
    push_req(8'hFF, 8'd9, 8'd200, 1'b0);
    push_req(8'h01, 8'd17, 8'd17, 1'b1);
    push_req(8'hAA, 8'd24, 8'd0, 1'b0);
    push_req(8'h55, 8'd24, 8'd0, 1'b0);
    push_req(8'h80, 8'd24, 8'd12, 1'b1);      // reported differs from counted
    push_req(8'h01, 8'd255, 8'd1, 1'b1);
    push_req(8'h80, 8'd8, 8'd1, 1'b1);
    push_req(8'h80, 8'd7, 8'd0, 1'b1);        // msb beyond a 7-sector track
    push_req(8'h7F, 8'd7, 8'd7, 1'b1);
    fill_phase(PHASE_BYTES);

    for (int p = 0; p < 4; p++) begin
      drain();
      cfg_set(rev_list[p], cnt_list[p]);
      // long output hold while requests keep coming
      if (p == 1) hold_requests++;
      fill_phase(PHASE_BYTES);
    end
    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d bitmap bytes and %0d track results over 5 register settings",
             bytes_accepted, results_checked);
    $display("flag hits: invalid %0d, exceeds %0d, mismatch %0d; long output holds %0d",
             invalid_seen, exceeds_seen, mismatch_seen, hold_requests);
    if (err_count == 0 && expected_tracks.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/btcc_pkg.sv
rtl/core/btcc_byte_eval.sv
rtl/core/btcc_track_accum.sv
rtl/core/bam_track_consistency_checker_unit.sv
tb/tb_bam_track_consistency_checker_unit.sv
